// ----- sv/assert_macros.svh -----
// assertion helpers shared by the chorus rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define STLC_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define STLC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/stlc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stlc_pkg;

    localparam int STLC_DELAY_DEPTH  = 1024;
    localparam int STLC_SAMPLE_WIDTH = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GAIN_W      = 17;
    localparam int DELAY_W     = 18;
    localparam int PHASE_W     = 32;
    localparam int LFO_W       = 18;

    localparam logic [GAIN_W-1:0]  GAIN_ONE   = 17'd65536;
    localparam logic [PHASE_W-1:0] PHASE_HALF = 32'h8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RATE_STEP   = 3'd0,
        REG_DEPTH       = 3'd1,
        REG_WIDTH       = 3'd2,
        REG_MIX         = 3'd3,
        REG_BASE_DELAY  = 3'd4,
        REG_DEPTH_EXC   = 3'd5,
        REG_SMOOTH_STEP = 3'd6
    } cfg_reg_t;

    // shift right by n, round to nearest with ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int unsigned n);
        logic signed [63:0] half;
        logic signed [63:0] bias;
        half = 64'sd1 <<< (n - 1);
        bias = x[63] ? half - 64'sd1 : half;
        return (x + bias) >>> n;
    endfunction

    function automatic logic [GAIN_W-1:0] cap_gain(input logic [GAIN_W-1:0] v);
        return (v > GAIN_ONE) ? GAIN_ONE : v;
    endfunction

    // triangle in q1.16, +1 at a quarter cycle and -1 at three quarters
    function automatic logic signed [LFO_W-1:0] tri_wave(input logic [PHASE_W-1:0] p);
        logic signed [19:0] q;
        logic signed [19:0] r;
        q = $signed({2'b00, p[31:14]});
        if (p < 32'h4000_0000) begin
            r = q;
        end else if (p < 32'hC000_0000) begin
            r = 20'sd131072 - q;
        end else begin
            r = q - 20'sd262144;
        end
        return r[LFO_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/stlc_dmem.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stlc_dmem #(
    parameter int DEPTH = stlc_pkg::STLC_DELAY_DEPTH,
    parameter int WIDTH = stlc_pkg::STLC_SAMPLE_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              wr_en,
    input  wire  [AW-1:0]    wr_addr,
    input  wire  [WIDTH-1:0] wr_data,
    input  wire              rd_en,
    input  wire  [AW-1:0]    rd_addr_a,
    input  wire  [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);
    import stlc_pkg::*;

    localparam logic [AW:0] FULL = (AW + 1)'(DEPTH);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;
    logic             vld_a_reg;
    logic             vld_b_reg;
    logic [AW:0]      fill_reg;
    logic [AW:0]      fill_next;

    // writes arrive in address order from zero, so entries at or above the
    // fill count were never written and read as zero
    always_comb begin
        fill_next = fill_reg;
        if (wr_en && fill_reg != FULL) begin
            fill_next = fill_reg + (AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg  <= mem_array[rd_addr_a];
            rd_b_reg  <= mem_array[rd_addr_b];
            vld_a_reg <= ({1'b0, rd_addr_a} < fill_reg);
            vld_b_reg <= ({1'b0, rd_addr_b} < fill_reg);
        end
    end

    assign rd_data_a = vld_a_reg ? rd_a_reg : '0;
    assign rd_data_b = vld_b_reg ? rd_b_reg : '0;

    `STLC_ASSERT_IMPLY(a_fill_order, aclk, aresetn, wr_en && fill_reg != FULL, wr_addr == fill_reg[AW-1:0], "write out of fill order")
    `STLC_ASSERT_IMPLY(a_no_rw_overlap, aclk, aresetn, rd_en, !wr_en, "read and write in one cycle")
    `STLC_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= FULL, "fill count past depth")

endmodule

`default_nettype wire

// ----- sv/stereo_triangle_lfo_chorus.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Stereo chorus: each request writes s_mono_in into a circular delay memory
// and reads two linearly interpolated taps whose delay follows two triangle
// LFOs half a cycle apart; the taps are pulled toward their mean by width,
// scaled by mix and added to the dry samples with saturation. Requests are
// taken only while idle: a sequencer walks each sample through smoothing, two
// modulation multiplies, the delay clamp, one read step per tap on the memory's
// two read ports, interpolation, width and mix, and a finished result waits in
// the output register while the next request is taken. The delay memory needs
// no clearing pass after reset: a fill count makes never-written entries read
// as zero. Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must do so only while no request is in flight; the block does not enforce it.
module stereo_triangle_lfo_chorus #(
    parameter int DELAY_DEPTH  = stlc_pkg::STLC_DELAY_DEPTH,
    parameter int SAMPLE_WIDTH = stlc_pkg::STLC_SAMPLE_WIDTH
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [stlc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [stlc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  signed [SAMPLE_WIDTH-1:0]       s_mono_in,
    input  wire  signed [SAMPLE_WIDTH-1:0]       s_dry_left,
    input  wire  signed [SAMPLE_WIDTH-1:0]       s_dry_right,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       m_out_left,
    output logic signed [SAMPLE_WIDTH-1:0]       m_out_right
);
    import stlc_pkg::*;

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int DCL_W = AW + 8;

    localparam logic signed [31:0] DELAY_MAX  = 32'((DELAY_DEPTH - 2) * 256);
    localparam logic [AW:0]        DEPTH_EXT  = (AW + 1)'(DELAY_DEPTH);
    localparam logic [AW-1:0]      LAST_INDEX = AW'(DELAY_DEPTH - 1);
    localparam logic signed [SW+3:0] SAMPLE_MAX = (SW + 4)'((longint'(1) <<< (SW - 1)) - 1);
    localparam logic signed [SW+3:0] SAMPLE_MIN = ~SAMPLE_MAX;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMAPPLY,
        ST_MODMUL,
        ST_TAPMUL,
        ST_ADDR,
        ST_READ_L,
        ST_READ_R,
        ST_LERP,
        ST_TAP_R,
        ST_WIDTH,
        ST_WET,
        ST_MIX,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [PHASE_W-1:0] rate_tgt_reg;
    logic [GAIN_W-1:0]  depth_tgt_reg;
    logic [GAIN_W-1:0]  width_tgt_reg;
    logic [GAIN_W-1:0]  mix_tgt_reg;
    logic [DELAY_W-1:0] base_delay_reg;
    logic [DELAY_W-1:0] depth_exc_reg;
    logic [GAIN_W-1:0]  smooth_step_reg;

    // per-sample state
    logic [PHASE_W-1:0] rate_s_reg;
    logic [PHASE_W-1:0] rate_s_next;
    logic [GAIN_W-1:0]  depth_s_reg;
    logic [GAIN_W-1:0]  depth_s_next;
    logic [GAIN_W-1:0]  width_s_reg;
    logic [GAIN_W-1:0]  width_s_next;
    logic [GAIN_W-1:0]  mix_s_reg;
    logic [GAIN_W-1:0]  mix_s_next;
    logic [PHASE_W-1:0] phase_l_reg;
    logic [PHASE_W-1:0] phase_r_reg;
    logic [AW-1:0]      wi_reg;
    logic [AW-1:0]      wi_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic signed [SW-1:0] m_out_left_reg;
    logic signed [SW-1:0] m_out_right_reg;

    // datapath registers
    logic signed [SW-1:0]    dry_l_reg;
    logic signed [SW-1:0]    dry_r_reg;
    logic signed [50:0]      sm_rate_prod_reg;
    logic signed [35:0]      sm_depth_prod_reg;
    logic signed [35:0]      sm_width_prod_reg;
    logic signed [35:0]      sm_mix_prod_reg;
    logic signed [LFO_W-1:0] lfo_l_reg;
    logic signed [LFO_W-1:0] lfo_r_reg;
    logic [34:0]             dexc_reg;
    logic signed [53:0]      mod_l_reg;
    logic signed [53:0]      mod_r_reg;
    logic [DCL_W-1:0]        dcl_l_reg;
    logic [DCL_W-1:0]        dcl_r_reg;
    logic signed [SW-1:0]    lerp_a_reg;
    logic signed [SW+9:0]    lerp_prod_reg;
    logic signed [SW-1:0]    tap_l_reg;
    logic signed [SW-1:0]    tap_r_reg;
    logic signed [SW:0]      wsum_reg;
    logic signed [SW+18:0]   wdiff_reg;
    logic signed [SW:0]      wet_l_reg;
    logic signed [SW:0]      wet_r_reg;
    logic signed [SW+18:0]   mixp_l_reg;
    logic signed [SW+18:0]   mixp_r_reg;

    // combinational
    logic                  accept;
    logic                  out_load;
    logic [GAIN_W-1:0]     step_cap;
    logic signed [GAIN_W:0] step_s;
    logic signed [32:0]    rate_err;
    logic signed [17:0]    depth_err;
    logic signed [17:0]    width_err;
    logic signed [17:0]    mix_err;
    logic signed [63:0]    rate_adj;
    logic signed [63:0]    depth_adj;
    logic signed [63:0]    width_adj;
    logic signed [63:0]    mix_adj;
    logic signed [63:0]    off_l;
    logic signed [63:0]    off_r;
    logic signed [31:0]    d_l;
    logic signed [31:0]    d_r;
    logic [DCL_W-1:0]      rd_dcl;
    logic [AW-1:0]         tap_int;
    logic [AW:0]           addr_sum;
    logic [AW:0]           addr_wrap;
    logic [AW-1:0]         addr_a;
    logic [AW-1:0]         addr_b;
    logic                  rd_en;
    logic signed [SW-1:0]  rd_data_a;
    logic signed [SW-1:0]  rd_data_b;
    logic [7:0]            lerp_frac;
    logic signed [SW:0]    lerp_diff;
    logic signed [SW+9:0]  lerp_prod_next;
    logic signed [63:0]    lerp_adj;
    logic signed [SW-1:0]  tap_value;
    logic signed [SW:0]    tap_diff;
    logic signed [SW+19:0] wet_center;
    logic signed [SW+19:0] wet_pl;
    logic signed [SW+19:0] wet_mi;
    logic signed [63:0]    wet_l_full;
    logic signed [63:0]    wet_r_full;
    logic signed [63:0]    mix_l_full;
    logic signed [63:0]    mix_r_full;
    logic signed [SW+3:0]  sum_l;
    logic signed [SW+3:0]  sum_r;
    logic signed [SW+3:0]  sat_l;
    logic signed [SW+3:0]  sat_r;

    function automatic logic [DCL_W-1:0] clamp_delay(input logic signed [31:0] d);
        if (d < 0) begin
            return '0;
        end
        if (d > DELAY_MAX) begin
            return DCL_W'(DELAY_MAX);
        end
        return DCL_W'(d);
    endfunction

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_load    = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid     = m_valid_reg;
    assign m_out_left  = m_out_left_reg;
    assign m_out_right = m_out_right_reg;

    // one-pole smoothers
    assign step_cap  = cap_gain(smooth_step_reg);
    assign step_s    = $signed({1'b0, step_cap});
    assign rate_err  = $signed({1'b0, rate_tgt_reg}) - $signed({1'b0, rate_s_reg});
    assign depth_err = $signed({1'b0, cap_gain(depth_tgt_reg)}) - $signed({1'b0, depth_s_reg});
    assign width_err = $signed({1'b0, cap_gain(width_tgt_reg)}) - $signed({1'b0, width_s_reg});
    assign mix_err   = $signed({1'b0, cap_gain(mix_tgt_reg)}) - $signed({1'b0, mix_s_reg});

    assign rate_adj     = rnd_shift(64'(sm_rate_prod_reg), 16);
    assign depth_adj    = rnd_shift(64'(sm_depth_prod_reg), 16);
    assign width_adj    = rnd_shift(64'(sm_width_prod_reg), 16);
    assign mix_adj      = rnd_shift(64'(sm_mix_prod_reg), 16);
    assign rate_s_next  = rate_s_reg + rate_adj[PHASE_W-1:0];
    assign depth_s_next = depth_s_reg + depth_adj[GAIN_W-1:0];
    assign width_s_next = width_s_reg + width_adj[GAIN_W-1:0];
    assign mix_s_next   = mix_s_reg + mix_adj[GAIN_W-1:0];

    // tap delays
    assign off_l = rnd_shift(64'(mod_l_reg), 32);
    assign off_r = rnd_shift(64'(mod_r_reg), 32);
    assign d_l   = $signed({14'b0, base_delay_reg}) + off_l[31:0];
    assign d_r   = $signed({14'b0, base_delay_reg}) + off_r[31:0];

    // delay zero is the sample written with this request
    assign rd_dcl    = (state_reg == ST_READ_R) ? dcl_r_reg : dcl_l_reg;
    assign tap_int   = rd_dcl[DCL_W-1:8];
    assign addr_sum  = {1'b0, wi_reg} + DEPTH_EXT - {1'b0, tap_int};
    assign addr_wrap = (addr_sum >= DEPTH_EXT) ? addr_sum - DEPTH_EXT : addr_sum;
    assign addr_a    = addr_wrap[AW-1:0];
    assign addr_b    = (addr_a == '0) ? LAST_INDEX : addr_a - AW'(1);
    assign rd_en     = (state_reg == ST_READ_L) || (state_reg == ST_READ_R);

    // left data is back during ST_READ_R, right data during ST_LERP
    assign lerp_frac      = (state_reg == ST_LERP) ? dcl_r_reg[7:0] : dcl_l_reg[7:0];
    assign lerp_diff      = {rd_data_b[SW-1], rd_data_b} - {rd_data_a[SW-1], rd_data_a};
    assign lerp_prod_next = lerp_diff * $signed({1'b0, lerp_frac});
    assign lerp_adj       = rnd_shift(64'(lerp_prod_reg), 8);
    assign tap_value      = lerp_a_reg + lerp_adj[SW-1:0];

    // width and mix
    assign tap_diff   = {tap_l_reg[SW-1], tap_l_reg} - {tap_r_reg[SW-1], tap_r_reg};
    assign wet_center = (SW + 20)'(wsum_reg) <<< 16;
    assign wet_pl     = wet_center + (SW + 20)'(wdiff_reg);
    assign wet_mi     = wet_center - (SW + 20)'(wdiff_reg);
    assign wet_l_full = rnd_shift(64'(wet_pl), 17);
    assign wet_r_full = rnd_shift(64'(wet_mi), 17);

    assign mix_l_full = rnd_shift(64'(mixp_l_reg), 16);
    assign mix_r_full = rnd_shift(64'(mixp_r_reg), 16);
    assign sum_l      = (SW + 4)'(dry_l_reg) + mix_l_full[SW+3:0];
    assign sum_r      = (SW + 4)'(dry_r_reg) + mix_r_full[SW+3:0];
    assign sat_l      = (sum_l > SAMPLE_MAX) ? SAMPLE_MAX : ((sum_l < SAMPLE_MIN) ? SAMPLE_MIN : sum_l);
    assign sat_r      = (sum_r > SAMPLE_MAX) ? SAMPLE_MAX : ((sum_r < SAMPLE_MIN) ? SAMPLE_MIN : sum_r);

    assign wi_next = (wi_reg == LAST_INDEX) ? '0 : wi_reg + AW'(1);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SMAPPLY;
                end
            end
            ST_SMAPPLY: state_next = ST_MODMUL;
            ST_MODMUL:  state_next = ST_TAPMUL;
            ST_TAPMUL:  state_next = ST_ADDR;
            ST_ADDR:    state_next = ST_READ_L;
            ST_READ_L:  state_next = ST_READ_R;
            ST_READ_R:  state_next = ST_LERP;
            ST_LERP:    state_next = ST_TAP_R;
            ST_TAP_R:   state_next = ST_WIDTH;
            ST_WIDTH:   state_next = ST_WET;
            ST_WET:     state_next = ST_MIX;
            ST_MIX:     state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            rate_tgt_reg    <= '0;
            depth_tgt_reg   <= '0;
            width_tgt_reg   <= GAIN_ONE;
            mix_tgt_reg     <= '0;
            base_delay_reg  <= '0;
            depth_exc_reg   <= '0;
            smooth_step_reg <= GAIN_ONE;
            rate_s_reg      <= '0;
            depth_s_reg     <= '0;
            width_s_reg     <= GAIN_ONE;
            mix_s_reg       <= '0;
            phase_l_reg     <= '0;
            phase_r_reg     <= PHASE_HALF;
            wi_reg          <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_RATE_STEP:   rate_tgt_reg    <= cfg_wdata;
                    REG_DEPTH:       depth_tgt_reg   <= cfg_wdata[GAIN_W-1:0];
                    REG_WIDTH:       width_tgt_reg   <= cfg_wdata[GAIN_W-1:0];
                    REG_MIX:         mix_tgt_reg     <= cfg_wdata[GAIN_W-1:0];
                    REG_BASE_DELAY:  base_delay_reg  <= cfg_wdata[DELAY_W-1:0];
                    REG_DEPTH_EXC:   depth_exc_reg   <= cfg_wdata[DELAY_W-1:0];
                    REG_SMOOTH_STEP: smooth_step_reg <= cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_SMAPPLY) begin
                rate_s_reg  <= rate_s_next;
                depth_s_reg <= depth_s_next;
                width_s_reg <= width_s_next;
                mix_s_reg   <= mix_s_next;
            end
            if (out_load) begin
                m_out_left_reg  <= sat_l[SW-1:0];
                m_out_right_reg <= sat_r[SW-1:0];
                phase_l_reg     <= phase_l_reg + rate_s_reg;
                phase_r_reg     <= phase_r_reg + rate_s_reg;
                wi_reg          <= wi_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    dry_l_reg         <= s_dry_left;
                    dry_r_reg         <= s_dry_right;
                    sm_rate_prod_reg  <= step_s * rate_err;
                    sm_depth_prod_reg <= step_s * depth_err;
                    sm_width_prod_reg <= step_s * width_err;
                    sm_mix_prod_reg   <= step_s * mix_err;
                    lfo_l_reg         <= tri_wave(phase_l_reg);
                    lfo_r_reg         <= tri_wave(phase_r_reg);
                end
            end
            ST_MODMUL: dexc_reg <= depth_s_reg * depth_exc_reg;
            ST_TAPMUL: begin
                mod_l_reg <= $signed({1'b0, dexc_reg}) * lfo_l_reg;
                mod_r_reg <= $signed({1'b0, dexc_reg}) * lfo_r_reg;
            end
            ST_ADDR: begin
                dcl_l_reg <= clamp_delay(d_l);
                dcl_r_reg <= clamp_delay(d_r);
            end
            ST_READ_R: begin
                lerp_prod_reg <= lerp_prod_next;
                lerp_a_reg    <= rd_data_a;
            end
            ST_LERP: begin
                tap_l_reg     <= tap_value;
                lerp_prod_reg <= lerp_prod_next;
                lerp_a_reg    <= rd_data_a;
            end
            ST_TAP_R: tap_r_reg <= tap_value;
            ST_WIDTH: begin
                wsum_reg  <= {tap_l_reg[SW-1], tap_l_reg} + {tap_r_reg[SW-1], tap_r_reg};
                wdiff_reg <= $signed({1'b0, width_s_reg}) * tap_diff;
            end
            ST_WET: begin
                wet_l_reg <= wet_l_full[SW:0];
                wet_r_reg <= wet_r_full[SW:0];
            end
            ST_MIX: begin
                mixp_l_reg <= $signed({1'b0, mix_s_reg}) * wet_l_reg;
                mixp_r_reg <= $signed({1'b0, mix_s_reg}) * wet_r_reg;
            end
            default: ;
        endcase
    end

    stlc_dmem #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (SAMPLE_WIDTH)
    ) u_dmem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (accept),
        .wr_addr   (wi_reg),
        .wr_data   (s_mono_in),
        .rd_en     (rd_en),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    `STLC_ASSERT_ALWAYS(a_phase_offset, aclk, aresetn, (phase_r_reg - phase_l_reg) == PHASE_HALF, "lfo phases lost their half cycle offset")
    `STLC_ASSERT_ALWAYS(a_gain_range, aclk, aresetn, depth_s_reg <= GAIN_ONE && width_s_reg <= GAIN_ONE && mix_s_reg <= GAIN_ONE, "smoothed gain above one")
    `STLC_ASSERT_IMPLY(a_result_source, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_OUT), "result raised outside output step")

endmodule

`default_nettype wire

// ----- verif/chorus_output_checker.sv -----
`timescale 1ns / 1ps

module chorus_output_checker (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_wr_en,
    input  logic [stlc_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [stlc_pkg::CFG_DATA_W-1:0]             cfg_wdata,
    input  logic                                        s_valid,
    input  logic                                        s_ready,
    input  logic signed [stlc_pkg::STLC_SAMPLE_WIDTH-1:0] s_mono_in,
    input  logic signed [stlc_pkg::STLC_SAMPLE_WIDTH-1:0] s_dry_left,
    input  logic signed [stlc_pkg::STLC_SAMPLE_WIDTH-1:0] s_dry_right,
    input  logic                                        m_valid,
    input  logic                                        m_ready,
    input  logic signed [stlc_pkg::STLC_SAMPLE_WIDTH-1:0] m_out_left,
    input  logic signed [stlc_pkg::STLC_SAMPLE_WIDTH-1:0] m_out_right,
    output int unsigned                                 fail_count,
    output int unsigned                                 outstanding,
    output int unsigned                                 checked
);
    import stlc_pkg::*;

    localparam int     SW        = STLC_SAMPLE_WIDTH;
    localparam int     DEPTH     = STLC_DELAY_DEPTH;
    localparam longint ONE       = 65536;
    localparam longint SAMPLE_HI = (longint'(1) << (SW - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
    localparam longint DELAY_MAX = longint'(DEPTH - 2) * 256;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } stereo_pair_t;

    // register copies
    longint rate_tgt, depth_tgt, width_tgt, mix_tgt, base_dly, excursion, smooth_k;

    // chorus state
    longint      echo_mem [DEPTH];
    int          wr_ptr;
    logic [31:0] lfo_phase_l, lfo_phase_r;
    longint      rate_s, depth_s, width_s, mix_s;

    stereo_pair_t expected_q [$];
    int unsigned  n_fail = 0;
    int unsigned  n_checked = 0;

    function automatic longint round_away(input longint x, input int n);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (longint'(1) << (n - 1))) >>> n;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic longint gain_clip(input longint v);
        return (v > ONE) ? ONE : v;
    endfunction

    function automatic longint glide(input longint cur, input longint tgt, input longint k);
        return cur + round_away(k * (tgt - cur), 16);
    endfunction

    // q1.16 triangle, rising through zero at phase zero
    function automatic longint lfo_triangle(input logic [31:0] p);
        longint q;
        q = longint'(p[31:14]);
        if (p < 32'h4000_0000) begin
            return q;
        end else if (p < 32'hC000_0000) begin
            return 131072 - q;
        end
        return q - 262144;
    endfunction

    function automatic logic signed [SW-1:0] sample_clip(input longint x);
        longint c;
        c = (x > SAMPLE_HI) ? SAMPLE_HI : ((x < SAMPLE_LO) ? SAMPLE_LO : x);
        return c[SW-1:0];
    endfunction

    function automatic longint tap_read(input logic [31:0] ph);
        longint d, a, b, frac;
        int     whole, ia, ib;
        d = base_dly + round_away(depth_s * excursion * lfo_triangle(ph), 32);
        if (d < 0) begin
            d = 0;
        end
        if (d > DELAY_MAX) begin
            d = DELAY_MAX;
        end
        whole = int'(d >>> 8);
        frac  = d & 255;
        // delay zero is the sample written by this request
        ia = (wr_ptr + DEPTH - whole) % DEPTH;
        ib = (wr_ptr + 2 * DEPTH - whole - 1) % DEPTH;
        a  = echo_mem[ia];
        b  = echo_mem[ib];
        return a + round_away((b - a) * frac, 8);
    endfunction

    task automatic clear_state();
        rate_tgt    = 0;
        depth_tgt   = 0;
        width_tgt   = ONE;
        mix_tgt     = 0;
        base_dly    = 0;
        excursion   = 0;
        smooth_k    = ONE;
        foreach (echo_mem[i]) begin
            echo_mem[i] = 0;
        end
        wr_ptr      = 0;
        lfo_phase_l = '0;
        lfo_phase_r = PHASE_HALF;
        rate_s      = 0;
        depth_s     = 0;
        width_s     = ONE;
        mix_s       = 0;
        expected_q.delete();
    endtask

    task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (cfg_reg_t'(idx))
            REG_RATE_STEP:   rate_tgt  = longint'(data[PHASE_W-1:0]);
            REG_DEPTH:       depth_tgt = longint'(data[GAIN_W-1:0]);
            REG_WIDTH:       width_tgt = longint'(data[GAIN_W-1:0]);
            REG_MIX:         mix_tgt   = longint'(data[GAIN_W-1:0]);
            REG_BASE_DELAY:  base_dly  = longint'(data[DELAY_W-1:0]);
            REG_DEPTH_EXC:   excursion = longint'(data[DELAY_W-1:0]);
            REG_SMOOTH_STEP: smooth_k  = longint'(data[GAIN_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic predict_output(input longint mono, input longint dl, input longint dr,
                                  output stereo_pair_t res);
        longint k, tap_l, tap_r, mid, spread, wet_l, wet_r;
        k       = gain_clip(smooth_k);
        rate_s  = glide(rate_s, rate_tgt, k) & 64'hFFFF_FFFF;
        depth_s = glide(depth_s, gain_clip(depth_tgt), k);
        width_s = glide(width_s, gain_clip(width_tgt), k);
        mix_s   = glide(mix_s, gain_clip(mix_tgt), k);

        echo_mem[wr_ptr] = mono;
        tap_l = tap_read(lfo_phase_l);
        tap_r = tap_read(lfo_phase_r);

        // centre plus or minus half the tap difference scaled by width
        mid    = (tap_l + tap_r) * ONE;
        spread = width_s * (tap_l - tap_r);
        wet_l  = round_away(mid + spread, 17);
        wet_r  = round_away(mid - spread, 17);

        res.left  = sample_clip(dl + round_away(mix_s * wet_l, 16));
        res.right = sample_clip(dr + round_away(mix_s * wet_r, 16));

        lfo_phase_l = lfo_phase_l + rate_s[31:0];
        lfo_phase_r = lfo_phase_r + rate_s[31:0];
        wr_ptr      = (wr_ptr + 1) % DEPTH;
    endtask

    task automatic report_mismatch(input string what, input longint got_v,
                                   input longint want_v);
        n_fail++;
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    always @(posedge aclk) begin : monitor
        stereo_pair_t want;
        stereo_pair_t fresh;
        if (!aresetn) begin
            clear_state();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no request pending", longint'(m_out_left), 0);
                end else begin
                    want = expected_q.pop_front();
                    n_checked++;
                    if (m_out_left !== want.left) begin
                        report_mismatch("out_left", longint'(m_out_left), longint'(want.left));
                    end
                    if (m_out_right !== want.right) begin
                        report_mismatch("out_right", longint'(m_out_right),
                                        longint'(want.right));
                    end
                end
            end
            if (cfg_wr_en) begin
                write_setting(cfg_index, cfg_wdata);
            end
            if (s_valid && s_ready) begin
                predict_output(longint'(s_mono_in), longint'(s_dry_left),
                               longint'(s_dry_right), fresh);
                expected_q.push_back(fresh);
            end
        end
        outstanding <= expected_q.size();
        fail_count  <= n_fail;
        checked     <= n_checked;
    end

endmodule

// ----- verif/stereo_triangle_lfo_chorus_tb.sv -----
`timescale 1ns / 1ps

module stereo_triangle_lfo_chorus_tb;
    import stlc_pkg::*;

    localparam int SW          = STLC_SAMPLE_WIDTH;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 92;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};
    localparam logic signed [SW-1:0] S_NEG1 = '1;
    localparam logic signed [SW-1:0] S_ZERO = '0;

    localparam logic [CFG_DATA_W-1:0] DELAY_TOP = 32'd261632;
    localparam logic [CFG_DATA_W-1:0] UNITY     = CFG_DATA_W'(GAIN_ONE);

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
    logic                   s_valid     = 1'b0;
    wire                    s_ready;
    logic signed [SW-1:0]   s_mono_in   = '0;
    logic signed [SW-1:0]   s_dry_left  = '0;
    logic signed [SW-1:0]   s_dry_right = '0;
    wire                    m_valid;
    logic                   m_ready     = 1'b0;
    wire signed [SW-1:0]    m_out_left;
    wire signed [SW-1:0]    m_out_right;

    int unsigned src_idle_pct  = 23;
    int unsigned snk_idle_pct  = 62;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned sent_count    = 0;
    int unsigned setting_count = 0;
    int unsigned cycle_count   = 0;

    stereo_triangle_lfo_chorus dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mono_in   (s_mono_in),
        .s_dry_left  (s_dry_left),
        .s_dry_right (s_dry_right),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_left  (m_out_left),
        .m_out_right (m_out_right)
    );

    chorus_output_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mono_in   (s_mono_in),
        .s_dry_left  (s_dry_left),
        .s_dry_right (s_dry_right),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_left  (m_out_left),
        .m_out_right (m_out_right),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("no progress after %0d cycles, %0d results still due",
                     cycle_count, outstanding);
            $display("stereo_triangle_lfo_chorus verification failed");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] rate,
                                 input logic [CFG_DATA_W-1:0] depth,
                                 input logic [CFG_DATA_W-1:0] width,
                                 input logic [CFG_DATA_W-1:0] mix,
                                 input logic [CFG_DATA_W-1:0] base,
                                 input logic [CFG_DATA_W-1:0] exc,
                                 input logic [CFG_DATA_W-1:0] smooth);
        write_reg(REG_RATE_STEP, rate);
        write_reg(REG_DEPTH, depth);
        write_reg(REG_WIDTH, width);
        write_reg(REG_MIX, mix);
        write_reg(REG_BASE_DELAY, base);
        write_reg(REG_DEPTH_EXC, exc);
        write_reg(REG_SMOOTH_STEP, smooth);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    task automatic send_item(input logic signed [SW-1:0] mono,
                             input logic signed [SW-1:0] dl,
                             input logic signed [SW-1:0] dr);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mono_in   <= mono;
        s_dry_left  <= dl;
        s_dry_right <= dr;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // the block is idle once every request has produced its result
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(9))
            0: return S_MAX;
            1: return S_MIN;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_rate();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h0800_0000);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return UNITY;
            2: return $urandom_range(131071, 65537);
            default: return $urandom_range(65536);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_delay(input int unsigned typical);
        case ($urandom_range(9))
            0: return 32'd0;
            1: return DELAY_TOP;
            2: return $urandom_range(262143);
            default: return $urandom_range(typical);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_smoothing();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return UNITY;
            2: return 32'd131071;
            3: return 32'd1;
            default: return $urandom_range(65536, 64);
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short taps sweeping all four triangle segments, full mix for saturation
        apply_setting(32'h2000_0000, UNITY, UNITY, UNITY, 32'd768, 32'd640, UNITY);
        send_item(S_MAX, S_MAX, S_MAX);
        send_item(S_MAX, S_MAX, S_MAX);
        send_item(S_MIN, S_MIN, S_MIN);
        send_item(S_MIN, S_MIN, S_MIN);
        send_item(S_MAX, S_ZERO, S_ZERO);
        send_item(S_ZERO, S_MAX, S_MIN);
        send_item(S_NEG1, S_NEG1, S_NEG1);
        send_item(S_MIN, S_MAX, S_MIN);
        wait_for_results();

        // gains above one, delay pinned at the top, phase step wrapping
        apply_setting(32'hFFFF_FFFF, 32'd131071, 32'd131071, 32'd131071,
                      DELAY_TOP, DELAY_TOP, 32'd131071);
        send_item(S_MAX, S_MAX, S_MIN);
        send_item(S_MIN, S_MIN, S_MAX);
        send_item(S_ZERO, S_ZERO, S_ZERO);
        send_item(S_MAX, S_NEG1, S_ZERO);
        send_item(S_MIN, S_ZERO, S_NEG1);
        send_item(S_NEG1, S_MAX, S_MAX);
        wait_for_results();

        // zero width gives mono centre, excursion larger than base pins delay at zero at the LFO's negative peak
        apply_setting(32'h4000_0000, UNITY, 32'd0, 32'd49152, 32'd128, DELAY_TOP, UNITY);
        send_item(S_MAX, S_ZERO, S_ZERO);
        send_item(S_MIN, S_MAX, S_MIN);
        send_item(S_MAX, S_MIN, S_MAX);
        send_item(S_NEG1, S_ZERO, S_ZERO);
        send_item(S_MIN, S_NEG1, S_NEG1);
        wait_for_results();

        // tiny smoothing step: smoothed gains barely move toward their targets
        apply_setting(32'h0100_0000, 32'd0, UNITY, 32'd0, 32'd512, 32'd256, 32'd1);
        send_item(S_MAX, S_MAX, S_MAX);
        send_item(S_MIN, S_MIN, S_MIN);
        send_item(S_ZERO, S_MAX, S_MIN);
        send_item(S_MAX, S_ZERO, S_NEG1);
        wait_for_results();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            src_idle_pct = (ph < 2) ? 23 : ((ph < 4) ? 62 : 0);
            snk_idle_pct = (ph < 2) ? 62 : ((ph < 4) ? 23 : 0);
            apply_setting(pick_rate(), pick_gain(), pick_gain(), pick_gain(),
                          pick_delay(200 * 256), pick_delay(120 * 256), pick_smoothing());
            repeat (PHASE_ITEMS) begin
                send_item(pick_sample(), pick_sample(), pick_sample());
            end
            wait_for_results();
        end

        repeat (40) @(posedge aclk);

        $display("chorus run: %0d requests under %0d register settings, %0d stereo results compared",
                 sent_count, setting_count, checked);
        $display("covered sender and receiver stalls, saturation, delay clamps, gains above one, slow glides");
        if (fail_count == 0 && outstanding == 0) begin
            $display("stereo_triangle_lfo_chorus verification clean");
        end else begin
            $display("stereo_triangle_lfo_chorus verification failed");
        end
        $finish;
    end

endmodule

// ----- stereo_triangle_lfo_chorus.f -----
+incdir+sv
sv/stlc_pkg.sv
sv/stlc_dmem.sv
sv/stereo_triangle_lfo_chorus.sv
verif/chorus_output_checker.sv
verif/stereo_triangle_lfo_chorus_tb.sv
